// ===== hdl/jfc_pkg.sv =====
// ---------------------------------------------------------------------------
// Journal frame checker package
// Shared codes, the result record type and the CRC-32 byte update.
// ---------------------------------------------------------------------------
package jfc_pkg;

   localparam logic [2:0] ST_RUNNING      = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER   = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE    = 3'd2;
   localparam logic [2:0] ST_CRC_MISMATCH = 3'd3;
   localparam logic [2:0] ST_TRUNCATED    = 3'd4;
   localparam logic [2:0] ST_CLEAN_END    = 3'd5;

   localparam logic [1:0] PH_MAGIC   = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [23:0] MAX_FRAME_RESET = 24'h01_0000;
   localparam logic [31:0] MAGIC_LEN_BYTES = 32'd8;
   localparam logic [31:0] HEADER_LEN_BYTES = 32'd8;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_good;
      logic [2:0]  status;
      logic [31:0] frames_accepted;
      logic [31:0] good_offset;
   } rsp_type;

   // Expected byte of the stream magic "PFJRNL1\n" at a given position.
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h50;
         3'd1:    b = 8'h46;
         3'd2:    b = 8'h4A;
         3'd3:    b = 8'h52;
         3'd4:    b = 8'h4E;
         3'd5:    b = 8'h4C;
         3'd6:    b = 8'h31;
         default: b = 8'h0A;
      endcase
      return b;
   endfunction

   // Reflected CRC-32 update by one byte, unrolled over its eight bits.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ===== hdl/jfc_rsp_buffer.sv =====
// ---------------------------------------------------------------------------
// Journal frame checker result buffer
// Output register with a skid stage, so a result can be taken every cycle
// while the next item is accepted, unless the skid stage is full.
// ---------------------------------------------------------------------------
module jfc_rsp_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  jfc_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output jfc_pkg::rsp_type out_data
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   jfc_pkg::rsp_type main_data_ff;
   jfc_pkg::rsp_type skid_data_ff;
   logic             push;
   logic             pop;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign push      = in_valid & in_ready;
   assign pop       = main_valid_ff & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push && (!main_valid_ff || pop)) begin
         main_valid_ff <= 1'b1;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_ff <= skid_data_ff;
         end
      end else if (push && (!main_valid_ff || pop)) begin
         main_data_ff <= in_data;
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

   // The skid stage only fills behind an occupied output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

endmodule

// ===== hdl/journal_frame_checker.sv =====
// ---------------------------------------------------------------------------
// Journal frame checker
// Checks the magic, frame lengths and CRC-32 of a journal byte stream and
// passes payload bytes through with running status and counts.
// ---------------------------------------------------------------------------
// A result is registered in the output register, or in the skid stage behind it.
// Throughput: one item per cycle; the CRC byte update, length compare and
// saturating counters all sit between the state registers and the result register.
// req_ready drops only while two results wait at the output.
// Synchronous reset returns to the magic check, clears the record count and status,
// sets the good offset to 8, the frame limit to 65536 and empties the result buffer.
module journal_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_frame_good,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_frames_accepted,
   output logic [31:0] rsp_good_offset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   logic [23:0] max_frame_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] field_count_ff, field_count_in;
   logic [31:0] frame_length_ff, frame_length_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] running_ff, running_in;
   logic [31:0] record_count_ff, record_count_in;
   logic [31:0] good_offset_ff, good_offset_in;
   logic [2:0]  status_ff, status_in;

   logic        accept;
   logic        pvalid;
   logic        good;
   logic        finish;
   logic [31:0] finish_crc;
   logic [31:0] crc_next;
   logic [23:0] count_inc;
   logic [33:0] offset_sum;
   logic [2:0]  pos;
   jfc_pkg::rsp_type rsp_in;
   jfc_pkg::rsp_type rsp_out;

   assign accept    = req_valid & req_ready;
   assign count_inc = field_count_ff + 24'd1;
   assign pos       = field_count_ff[2:0];
   assign crc_next  = jfc_pkg::crc32_byte(running_ff, req_data_byte);
   assign offset_sum = {2'b00, good_offset_ff} + {2'b00, jfc_pkg::HEADER_LEN_BYTES}
                       + {2'b00, frame_length_ff};

   always_comb begin
      phase_in        = phase_ff;
      field_count_in  = field_count_ff;
      frame_length_in = frame_length_ff;
      expected_in     = expected_ff;
      running_in      = running_ff;
      record_count_in = record_count_ff;
      good_offset_in  = good_offset_ff;
      status_in       = status_ff;
      pvalid          = 1'b0;
      good            = 1'b0;
      finish          = 1'b0;
      finish_crc      = jfc_pkg::ALL_ONES;

      if (status_ff == jfc_pkg::ST_RUNNING) begin
         if (req_kind) begin
            if (phase_ff == jfc_pkg::PH_MAGIC) begin
               status_in = jfc_pkg::ST_BAD_HEADER;
            end else if (phase_ff == jfc_pkg::PH_HEADER && field_count_ff == 24'd0) begin
               status_in = jfc_pkg::ST_CLEAN_END;
            end else begin
               status_in = jfc_pkg::ST_TRUNCATED;
            end
         end else begin
            unique case (phase_ff)
               jfc_pkg::PH_MAGIC: begin
                  if (req_data_byte != jfc_pkg::magic_byte(pos)) begin
                     status_in = jfc_pkg::ST_BAD_HEADER;
                  end else if ({8'd0, count_inc} >= jfc_pkg::MAGIC_LEN_BYTES) begin
                     phase_in       = jfc_pkg::PH_HEADER;
                     field_count_in = 24'd0;
                  end else begin
                     field_count_in = count_inc;
                  end
               end
               jfc_pkg::PH_HEADER: begin
                  if (!pos[2]) begin
                     frame_length_in[{pos[1:0], 3'b000} +: 8] = req_data_byte;
                  end else begin
                     expected_in[{pos[1:0], 3'b000} +: 8] = req_data_byte;
                  end
                  field_count_in = count_inc;
                  if ({8'd0, count_inc} >= jfc_pkg::HEADER_LEN_BYTES) begin
                     field_count_in = 24'd0;
                     running_in     = jfc_pkg::ALL_ONES;
                     if (frame_length_in > {8'd0, max_frame_ff}) begin
                        status_in = jfc_pkg::ST_TOO_LARGE;
                     end else if (frame_length_in == 32'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = jfc_pkg::PH_PAYLOAD;
                     end
                  end
               end
               jfc_pkg::PH_PAYLOAD: begin
                  pvalid         = 1'b1;
                  running_in     = crc_next;
                  finish_crc     = crc_next;
                  field_count_in = count_inc;
                  if ({8'd0, count_inc} >= frame_length_ff) begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase

            // Closing a frame: an empty frame checks against the initial CRC.
            if (finish) begin
               if ((finish_crc ^ jfc_pkg::ALL_ONES) != expected_in) begin
                  status_in = jfc_pkg::ST_CRC_MISMATCH;
               end else begin
                  good = 1'b1;
                  if (record_count_ff != jfc_pkg::ALL_ONES) begin
                     record_count_in = record_count_ff + 32'd1;
                  end
                  good_offset_in = (offset_sum[33:32] != 2'b00) ? jfc_pkg::ALL_ONES
                                                                : offset_sum[31:0];
                  phase_in       = jfc_pkg::PH_HEADER;
                  field_count_in = 24'd0;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_in.payload_byte    = pvalid ? req_data_byte : 8'd0;
      rsp_in.payload_valid   = pvalid;
      rsp_in.frame_good      = good;
      rsp_in.status          = status_in;
      rsp_in.frames_accepted = record_count_in;
      rsp_in.good_offset     = good_offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff    <= jfc_pkg::MAX_FRAME_RESET;
         phase_ff        <= jfc_pkg::PH_MAGIC;
         field_count_ff  <= 24'd0;
         frame_length_ff <= 32'd0;
         expected_ff     <= 32'd0;
         running_ff      <= jfc_pkg::ALL_ONES;
         record_count_ff <= 32'd0;
         good_offset_ff  <= jfc_pkg::MAGIC_LEN_BYTES;
         status_ff       <= jfc_pkg::ST_RUNNING;
      end else begin
         if (csr_wr_en) begin
            max_frame_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            field_count_ff  <= field_count_in;
            frame_length_ff <= frame_length_in;
            expected_ff     <= expected_in;
            running_ff      <= running_in;
            record_count_ff <= record_count_in;
            good_offset_ff  <= good_offset_in;
            status_ff       <= status_in;
         end
      end
   end

   jfc_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_payload_byte    = rsp_out.payload_byte;
   assign rsp_payload_valid   = rsp_out.payload_valid;
   assign rsp_frame_good      = rsp_out.frame_good;
   assign rsp_status          = rsp_out.status;
   assign rsp_frames_accepted = rsp_out.frames_accepted;
   assign rsp_good_offset     = rsp_out.good_offset;

   // A terminal status never changes until reset.
   assert property (@(posedge clock) disable iff (reset)
      (status_ff != jfc_pkg::ST_RUNNING) |=> (status_ff == $past(status_ff)))
      else $error("terminal status changed");

   // The good record count only grows.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (record_count_ff >= $past(record_count_ff)))
      else $error("record count went backward");

   // Inside a payload the byte count stays short of a nonzero frame length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jfc_pkg::PH_PAYLOAD && status_ff == jfc_pkg::ST_RUNNING)
         |-> ({8'd0, field_count_ff} < frame_length_ff))
      else $error("payload byte count reached the frame length");

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Journal frame checker testbench
// Streams the magic and CRC-32 framed records through the checker with random
// gaps and stalls on both channels, predicts every result item in step with
// the stream, and ends the one stream with a randomly chosen terminal status.
// ---------------------------------------------------------------------------
module testbench;

   typedef enum logic [1:0] {SP_MAGIC, SP_HEADER, SP_PAYLOAD, SP_STOPPED} stream_phase_type;
   typedef enum logic {ITEM_DATA = 1'b0, ITEM_END = 1'b1} item_kind_type;
   typedef enum logic [2:0] {
      END_CLEAN, END_CUT_HEADER, END_CUT_PAYLOAD, END_OVERSIZE, END_BAD_CRC
   } stream_ending_type;

   localparam int          CYCLE_LIMIT = 100000;
   localparam int          PHASE_ITEMS = 90;
   localparam int unsigned WHOLE_FRAME = 32'h7FFF_FFFF;
   localparam logic [63:0] MAGIC_WORD  = "PFJRNL1\n";

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_kind      = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_ready     = 1'b0;
   logic        csr_wr_en     = 1'b0;
   logic [23:0] csr_wr_data   = 24'h0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_frame_good;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_frames_accepted;
   logic [31:0] rsp_good_offset;

   // Checker state as predicted by the testbench, starting at reset values.
   stream_phase_type ph      = SP_MAGIC;
   logic [23:0]   field_pos  = 24'd0;
   logic [31:0]   frame_len  = 32'd0;
   logic [31:0]   want_crc   = 32'd0;
   logic [31:0]   run_crc    = jfc_pkg::ALL_ONES;
   logic [31:0]   frames_ok  = 32'd0;
   logic [31:0]   good_end   = 32'd8;
   logic [2:0]    cur_status = jfc_pkg::ST_RUNNING;
   logic [23:0]   max_len    = jfc_pkg::MAX_FRAME_RESET;

   jfc_pkg::rsp_type expected_rsp[$];
   jfc_pkg::rsp_type want;
   int      mismatches = 0;
   int      items_sent = 0;
   int      cycles     = 0;
   bit      idle_on    = 1'b1;
   logic    hold_rsp   = 1'b0;
   int      stall_left = 0;

   journal_frame_checker u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_valid   (rsp_payload_valid),
      .rsp_frame_good      (rsp_frame_good),
      .rsp_status          (rsp_status),
      .rsp_frames_accepted (rsp_frames_accepted),
      .rsp_good_offset     (rsp_good_offset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      int          k;
      c = crc ^ {24'd0, b};
      for (k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ 32'hEDB8_8320;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic void halt(input logic [2:0] code);
      cur_status = code;
      ph = SP_STOPPED;
   endfunction

   function automatic logic close_frame();
      logic [63:0] off;
      if ((run_crc ^ jfc_pkg::ALL_ONES) != want_crc) begin
         halt(jfc_pkg::ST_CRC_MISMATCH);
         return 1'b0;
      end
      if (frames_ok != jfc_pkg::ALL_ONES) frames_ok = frames_ok + 32'd1;
      off = {32'd0, good_end} + {32'd0, jfc_pkg::HEADER_LEN_BYTES} + {32'd0, frame_len};
      good_end = (off > {32'd0, jfc_pkg::ALL_ONES}) ? jfc_pkg::ALL_ONES : off[31:0];
      ph = SP_HEADER;
      field_pos = 24'd0;
      return 1'b1;
   endfunction

   // Advances the predicted state by one stream item and returns its result.
   function automatic jfc_pkg::rsp_type frame_step(input logic kind, input logic [7:0] b);
      jfc_pkg::rsp_type r;
      logic       pv;
      logic       good;
      logic [2:0] pos;
      pv = 1'b0;
      good = 1'b0;
      if (cur_status == jfc_pkg::ST_RUNNING) begin
         if (kind == ITEM_END) begin
            if (ph == SP_MAGIC) halt(jfc_pkg::ST_BAD_HEADER);
            else if (ph == SP_HEADER && field_pos == 24'd0) halt(jfc_pkg::ST_CLEAN_END);
            else halt(jfc_pkg::ST_TRUNCATED);
         end else if (ph == SP_MAGIC) begin
            if (b != MAGIC_WORD[63 - 8 * field_pos[2:0] -: 8]) begin
               halt(jfc_pkg::ST_BAD_HEADER);
            end else begin
               field_pos = field_pos + 24'd1;
               if (field_pos >= 24'd8) begin
                  ph = SP_HEADER;
                  field_pos = 24'd0;
               end
            end
         end else if (ph == SP_HEADER) begin
            pos = field_pos[2:0];
            if (pos < 3'd4) frame_len[8 * pos +: 8] = b;
            else want_crc[8 * (pos - 3'd4) +: 8] = b;
            field_pos = field_pos + 24'd1;
            if (field_pos >= 24'd8) begin
               field_pos = 24'd0;
               run_crc = jfc_pkg::ALL_ONES;
               if (frame_len > {8'd0, max_len}) halt(jfc_pkg::ST_TOO_LARGE);
               else if (frame_len == 32'd0) good = close_frame();
               else ph = SP_PAYLOAD;
            end
         end else if (ph == SP_PAYLOAD) begin
            pv = 1'b1;
            run_crc = crc_next(run_crc, b);
            field_pos = field_pos + 24'd1;
            if ({8'd0, field_pos} >= frame_len) good = close_frame();
         end
      end
      r.payload_byte    = pv ? b : 8'h00;
      r.payload_valid   = pv;
      r.frame_good      = good;
      r.status          = cur_status;
      r.frames_accepted = frames_ok;
      r.good_offset     = good_end;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            $display("%0t: result item with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = expected_rsp.pop_front();
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
            check_field("payload_valid", 32'(want.payload_valid), 32'(rsp_payload_valid));
            check_field("frame_good", 32'(want.frame_good), 32'(rsp_frame_good));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("frames_accepted", want.frames_accepted, rsp_frames_accepted);
            check_field("good_offset", want.good_offset, rsp_good_offset);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Result side: random stall bursts, plus a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input item_kind_type kind, input logic [7:0] b);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.insert(expected_rsp.size(), frame_step(kind, b));
      items_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [23:0] value);
      wait_drain();
      repeat (2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      max_len = value;
   endtask

   // Sends the first keep bytes of a frame; a whole frame when keep is large.
   task automatic send_frame(input logic [31:0] len, input bit corrupt, input int unsigned keep,
                             input bit extremes = 1'b0);
      logic [7:0]  body[$];
      logic [31:0] crc;
      int unsigned n;
      int unsigned i;
      n = (keep > 8) ? keep - 8 : 0;
      if (len < n) n = len;
      crc = jfc_pkg::ALL_ONES;
      for (i = 0; i < n; i++) begin
         if (extremes) body.insert(body.size(), i[0] ? 8'hFF : 8'h00);
         else body.insert(body.size(), 8'($urandom));
         crc = crc_next(crc, body[i]);
      end
      crc = ~crc;
      if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (i = 0; i < 8 && i < keep; i++) begin
         send_item(ITEM_DATA, (i < 4) ? len[8 * i +: 8] : crc[8 * (i - 4) +: 8]);
      end
      foreach (body[j]) send_item(ITEM_DATA, body[j]);
   endtask

   function automatic logic [31:0] pick_len();
      logic [31:0] cap;
      cap = ({8'd0, max_len} < 32'd40) ? {8'd0, max_len} : 32'd40;
      return $urandom_range(0, cap);
   endfunction

   task automatic test_magic();
      int i;
      for (i = 0; i < 8; i++) send_item(ITEM_DATA, MAGIC_WORD[63 - 8 * i -: 8]);
   endtask

   task automatic test_empty_frame();
      send_frame(32'd0, 1'b0, WHOLE_FRAME);
   endtask

   task automatic test_extreme_bytes();
      send_frame(32'd4, 1'b0, WHOLE_FRAME, 1'b1);
   endtask

   // With a zero limit only empty frames get through.
   task automatic test_zero_max();
      write_max_len(24'd0);
      send_frame(32'd0, 1'b0, WHOLE_FRAME);
   endtask

   task automatic test_random_frames();
      logic [23:0] settings[4];
      int          p;
      int          start;
      settings[0] = 24'd128;
      settings[1] = 24'hFF_FFFF;
      settings[2] = 24'($urandom_range(129, 4095));
      settings[3] = 24'($urandom_range(128, 1000));
      for (p = 0; p < 4; p++) begin
         write_max_len(settings[p]);
         idle_on = (p != 2);
         start = items_sent;
         // A frame exactly at the limit is still accepted.
         if (p == 0) send_frame({8'd0, max_len}, 1'b0, WHOLE_FRAME);
         while (items_sent - start < PHASE_ITEMS) send_frame(pick_len(), 1'b0, WHOLE_FRAME);
      end
   endtask

   task automatic test_backpressure();
      int start;
      idle_on = 1'b0;
      fork
         begin
            @(negedge clock);
            hold_rsp <= 1'b1;
            repeat (60) @(negedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      start = items_sent;
      while (items_sent - start < 40) send_frame(pick_len(), 1'b0, WHOLE_FRAME);
      wait_drain();
      idle_on = 1'b1;
   endtask

   // Only one terminal status can be reached per run; the seed picks which.
   task automatic test_terminal();
      stream_ending_type ending;
      logic [31:0]    len;
      int             k;
      idle_on = 1'b0;
      ending = stream_ending_type'($urandom_range(0, 4));
      case (ending)
         END_CLEAN: begin
            send_frame(pick_len(), 1'b0, WHOLE_FRAME);
            send_item(ITEM_END, 8'($urandom));
         end
         END_CUT_HEADER: begin
            send_frame(pick_len(), 1'b0, $urandom_range(1, 7));
            send_item(ITEM_END, 8'($urandom));
         end
         END_CUT_PAYLOAD: begin
            len = $urandom_range(1, 20);
            send_frame(len, 1'b0, 8 + $urandom_range(0, len - 1));
            send_item(ITEM_END, 8'($urandom));
         end
         END_OVERSIZE: begin
            if ($urandom_range(0, 1) == 0) len = {8'd0, max_len} + 32'd1;
            else len = $urandom | 32'h0100_0000;
            send_frame(len, 1'b0, 8);
         end
         default: begin
            send_frame(pick_len(), 1'b1, WHOLE_FRAME);
         end
      endcase
      // Everything after a terminal status must be ignored.
      for (k = 0; k < 6; k++) send_item(item_kind_type'($urandom_range(0, 1)), 8'($urandom));
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_magic();
      test_empty_frame();
      test_extreme_bytes();
      test_zero_max();
      test_random_frames();
      test_backpressure();
      test_terminal();
      wait_drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/jfc_pkg.sv
hdl/jfc_rsp_buffer.sv
hdl/journal_frame_checker.sv
tb/testbench.sv
